/* sv/hkrb_pkg.sv */
`timescale 1ns / 1ps

package hkrb_pkg;

  localparam int unsigned KeyW       = 16;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned ReportKeys = 6;
  localparam int unsigned ReportW    = ByteW * (ReportKeys + 1);

  // Modifier keys are 0xE0..0xE7: everything above the low three bits is fixed.
  localparam logic [KeyW-4:0] ModPrefix = 13'h001C;

  localparam logic [KeyW-1:0] NoKey = '0;

  typedef struct packed {
    logic load;     // latch the incoming event
    logic exec;     // apply the event to the modifier byte and the slot list
    logic pack;     // close the first gap in the slot list
    logic capture;  // move the finished report into the output register
  } cmd_t;

  typedef struct packed {
    logic hole;     // an empty slot lies ahead of a held key
  } status_t;

endpackage

/* sv/hkrb_ctrl.sv */
`timescale 1ns / 1ps

module hkrb_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  input  hkrb_pkg::status_t status_i,
  output hkrb_pkg::cmd_t    cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StExec = 2'd1;
  localparam logic [1:0] StPack = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !m_axis_tready;
    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          state_d    = StExec;
        end
      end
      StExec: begin
        cmd_o.exec = 1'b1;
        state_d    = StPack;
      end
      StPack: begin
        if (status_i.hole) begin
          cmd_o.pack = 1'b1;
        end else if (out_free) begin
          // The output register is free or being emptied in this cycle.
          cmd_o.capture = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* sv/hkrb_datapath.sv */
`timescale 1ns / 1ps

module hkrb_datapath #(
  parameter int unsigned SLOT_COUNT = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [hkrb_pkg::KeyW-1:0]    key_code_i,
  input  logic                         pressed_i,
  input  hkrb_pkg::cmd_t               cmd_i,
  output hkrb_pkg::status_t            status_o,
  output logic [hkrb_pkg::ReportW-1:0] report_o
);

  localparam int unsigned KeyW  = hkrb_pkg::KeyW;
  localparam int unsigned ByteW = hkrb_pkg::ByteW;

  logic [KeyW-1:0]  code_q;
  logic             pressed_q;
  logic [KeyW-1:0]  slot_q [SLOT_COUNT];
  logic [KeyW-1:0]  slot_d [SLOT_COUNT];
  logic [ByteW-1:0] mods_q, mods_d;
  logic [hkrb_pkg::ReportW-1:0] report_q;

  // Slot list padded with one empty entry so that shifting needs no edge case.
  logic [KeyW-1:0]     ext   [SLOT_COUNT+1];
  logic [SLOT_COUNT-1:0] nz_prev;
  logic [SLOT_COUNT:1]   tail_nz;
  logic [SLOT_COUNT-1:0] nz;
  logic [SLOT_COUNT-1:0] hole;
  logic [SLOT_COUNT:0]   past_hole;
  logic                  is_mod;
  logic [ByteW-1:0]      mod_bit;
  logic                  full;
  logic [ByteW-1:0]      mods_report;
  logic [ByteW-1:0]      key_byte [hkrb_pkg::ReportKeys];

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      ext[i] = slot_q[i];
      nz[i]  = (slot_q[i] != hkrb_pkg::NoKey);
    end
    ext[SLOT_COUNT] = hkrb_pkg::NoKey;
    nz_prev[0]      = 1'b1;
    for (int i = 1; i < SLOT_COUNT; i++) begin
      nz_prev[i] = nz[i-1];
    end
    tail_nz[SLOT_COUNT] = 1'b0;
    for (int i = SLOT_COUNT - 1; i >= 1; i--) begin
      tail_nz[i] = tail_nz[i+1] | nz[i];
    end
    past_hole[0] = 1'b0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      hole[i]        = !nz[i] && tail_nz[i+1];
      past_hole[i+1] = past_hole[i] | hole[i];
    end
  end

  assign status_o.hole = |hole;
  assign full          = nz[SLOT_COUNT-1];
  assign is_mod        = (code_q[KeyW-1:3] == hkrb_pkg::ModPrefix);
  assign mod_bit       = ByteW'(1) << code_q[2:0];

  always_comb begin
    mods_d = mods_q;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_d[i] = slot_q[i];
    end
    if (cmd_i.exec) begin
      if (is_mod) begin
        mods_d = pressed_q ? (mods_q | mod_bit) : (mods_q & ~mod_bit);
      end else if (pressed_q) begin
        // A full list drops its oldest key and takes the new one at the end.
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (full) begin
            slot_d[i] = (i == SLOT_COUNT - 1) ? code_q : ext[i+1];
          end else if (!nz[i] && nz_prev[i]) begin
            slot_d[i] = code_q;
          end
        end
      end else begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (slot_q[i] == code_q) begin
            slot_d[i] = hkrb_pkg::NoKey;
          end
        end
      end
    end else if (cmd_i.pack) begin
      // Everything from the first gap onward moves down by one slot.
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (past_hole[i+1]) begin
          slot_d[i] = ext[i+1];
        end
      end
    end
  end

  always_comb begin
    mods_report = mods_q;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      mods_report = mods_report | slot_q[i][KeyW-1:ByteW];
    end
  end

  for (genvar k = 0; k < hkrb_pkg::ReportKeys; k++) begin : g_key
    if (k < SLOT_COUNT) begin : g_slot
      assign key_byte[k] = slot_q[k][ByteW-1:0];
    end else begin : g_none
      assign key_byte[k] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mods_q <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_q[i] <= hkrb_pkg::NoKey;
      end
    end else begin
      mods_q <= mods_d;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_q[i] <= slot_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      code_q    <= key_code_i;
      pressed_q <= pressed_i;
    end
    if (cmd_i.capture) begin
      report_q[ByteW-1:0] <= mods_report;
      for (int k = 0; k < hkrb_pkg::ReportKeys; k++) begin
        report_q[ByteW*(k+1) +: ByteW] <= key_byte[k];
      end
    end
  end

  assign report_o = report_q;

endmodule

/* sv/hid_key_report_builder.sv */
`timescale 1ns / 1ps

// Channel  Direction  tdata                               tuser
// s_axis   in         [15:0] key_code                     [0] pressed
// m_axis   out        [7:0] report_modifiers,             none
//                     [15:8]..[55:48] report_key_0..5
//
// An event passes through the transfer, the slot update and the capture into the
// output register, and its report is valid on m_axis once it sits in that register.
// A release adds a pack step before the capture for each gap it leaves in the slot
// list (at most SLOT_COUNT - 1 gaps); the gap-closing loop runs these steps.
// A new event is taken while the previous report still waits on m_axis.
// Reset clears the slot list, the modifier byte and the control state at once.
// A stalled m_axis holds the next report in the pack step until it drains.
module hid_key_report_builder #(
  parameter int unsigned SLOT_COUNT = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [hkrb_pkg::KeyW-1:0]    s_axis_tdata,  // [15:0] key_code
  input  logic                         s_axis_tuser,  // [0] pressed
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [7:0] report_modifiers, then report_key_0 .. report_key_5, one byte each
  output logic [hkrb_pkg::ReportW-1:0] m_axis_tdata
);

  hkrb_pkg::cmd_t    cmd;
  hkrb_pkg::status_t status;

  hkrb_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  hkrb_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .key_code_i (s_axis_tdata),
    .pressed_i  (s_axis_tuser),
    .cmd_i      (cmd),
    .status_o   (status),
    .report_o   (m_axis_tdata)
  );

endmodule

/* tb/tb_hid_key_report_builder.sv */
`timescale 1ns / 1ps

module tb_hid_key_report_builder;

  localparam int unsigned KeyW       = hkrb_pkg::KeyW;
  localparam int unsigned ByteW      = hkrb_pkg::ByteW;
  localparam int unsigned ReportKeys = hkrb_pkg::ReportKeys;
  localparam int unsigned ReportW    = hkrb_pkg::ReportW;
  localparam logic [KeyW-1:0] NoKey  = hkrb_pkg::NoKey;
  localparam logic [KeyW-4:0] ModPrefix = hkrb_pkg::ModPrefix;

  localparam int unsigned Slots      = 6;
  localparam int unsigned RandEvents = 850;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainWait  = 3 + Slots + 8;

  typedef struct packed {
    logic [ReportKeys-1:0][ByteW-1:0] keys;
    logic [ByteW-1:0]                 mods;
  } report_t;

  typedef struct {
    logic [KeyW-1:0]  code;
    logic             pressed;
    bit               literal;
    logic [ByteW-1:0] lit_mods;
    logic [ByteW-1:0] lit_key0;
  } key_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [KeyW-1:0]     s_axis_tdata;   // [15:0] key_code
  logic                s_axis_tuser;   // [0] pressed
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [ReportW-1:0]  m_axis_tdata;   // [7:0] report_modifiers, [55:8] report_key_0..5

  // Shadow copy of the key list and modifier byte.
  logic [KeyW-1:0]  held_keys [Slots];
  logic [ByteW-1:0] held_mods;

  report_t pending_reports[$];
  int unsigned cycle_cnt;
  int unsigned err_cnt;
  int unsigned n_press, n_release, n_mod, n_drop, n_reports;
  bit quiet_gaps;

  hid_key_report_builder #(
    .SLOT_COUNT(Slots)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("tb_hid_key_report_builder NOT OK");
      $finish;
    end
  end

  function automatic int unsigned draw_gap();
    return quiet_gaps ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic int unsigned keys_in_use();
    int unsigned used;
    used = 0;
    for (int i = 0; i < Slots; i++) begin
      if (held_keys[i] != NoKey) used++;
    end
    return used;
  endfunction

  function automatic void compact_keys();
    logic [KeyW-1:0] packed_keys [Slots];
    int unsigned fill;
    fill = 0;
    for (int i = 0; i < Slots; i++) packed_keys[i] = NoKey;
    for (int i = 0; i < Slots; i++) begin
      if (held_keys[i] != NoKey) begin
        packed_keys[fill] = held_keys[i];
        fill++;
      end
    end
    for (int i = 0; i < Slots; i++) held_keys[i] = packed_keys[i];
  endfunction

  // Applies one key event to the shadow state and returns the report it yields.
  function automatic report_t apply_key_event(input logic [KeyW-1:0] code,
                                              input logic pressed);
    report_t rep;
    int unsigned used;
    if (code[KeyW-1:3] == ModPrefix) begin
      n_mod++;
      if (pressed) held_mods = held_mods | (8'h01 << code[2:0]);
      else held_mods = held_mods & ~(8'h01 << code[2:0]);
    end else if (pressed) begin
      n_press++;
      if (keys_in_use() >= Slots) begin
        // The list is full, so the oldest key gives way.
        held_keys[0] = NoKey;
        n_drop++;
      end
      compact_keys();
      used = keys_in_use();
      if (used < Slots) held_keys[used] = code;
    end else begin
      n_release++;
      for (int i = 0; i < Slots; i++) begin
        if (held_keys[i] == code) held_keys[i] = NoKey;
      end
      compact_keys();
    end
    rep.mods = held_mods;
    for (int i = 0; i < Slots; i++) rep.mods = rep.mods | held_keys[i][KeyW-1:ByteW];
    for (int i = 0; i < ReportKeys; i++) begin
      rep.keys[i] = (i < Slots) ? held_keys[i][ByteW-1:0] : '0;
    end
    return rep;
  endfunction

  // Sends one key event. The report comes from the shadow model unless the row
  // carries a literal one; the shadow state is updated either way.
  task automatic send_key_event(input logic [KeyW-1:0] code, input logic pressed,
                                input bit literal, input report_t lit_rep, input bit drain);
    int unsigned gap;
    report_t rep;
    gap = draw_gap();
    if (gap > 0 || drain) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      while (drain && pending_reports.size() != 0) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= code;
    s_axis_tuser  <= pressed;
    do @(posedge clk_i); while (!s_axis_tready);
    rep = apply_key_event(code, pressed);
    if (literal) rep = lit_rep;
    pending_reports = {pending_reports, rep};
  endtask

  // Report checker.
  always @(posedge clk_i) begin
    report_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      n_reports++;
      if (pending_reports.size() == 0) begin
        $error("report with no event waiting: 0x%014h", got);
        err_cnt++;
      end else begin
        want = pending_reports.pop_front();
        if (got.mods !== want.mods) begin
          $error("report_modifiers: expected 0x%02h, got 0x%02h", want.mods, got.mods);
          err_cnt++;
        end
        for (int i = 0; i < ReportKeys; i++) begin
          if (got.keys[i] !== want.keys[i]) begin
            $error("report_key_%0d: expected 0x%02h, got 0x%02h", i, want.keys[i],
                   got.keys[i]);
            err_cnt++;
          end
        end
      end
    end
  end

  // Report sink with random back-pressure.
  initial begin
    int unsigned gap;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    key_row_t rows [25];
    report_t lit_rep;
    logic [KeyW-1:0] pool [12];
    logic [KeyW-1:0] code;
    logic pressed;
    int unsigned pick, used;

    rows = '{
      '{16'h0000, 1'b0, 1'b1, 8'h00, 8'h00},  // release of no key right after reset
      '{16'h00E0, 1'b1, 1'b1, 8'h01, 8'h00},  // lowest modifier
      '{16'h00E7, 1'b1, 1'b1, 8'h81, 8'h00},  // highest modifier
      '{16'h0004, 1'b1, 1'b1, 8'h81, 8'h04},
      '{16'h0004, 1'b1, 1'b0, 8'h00, 8'h00},  // held key pressed again
      '{16'hFFFF, 1'b1, 1'b0, 8'h00, 8'h00},
      '{16'h0105, 1'b1, 1'b0, 8'h00, 8'h00},
      '{16'h8006, 1'b1, 1'b0, 8'h00, 8'h00},
      '{16'h0007, 1'b1, 1'b0, 8'h00, 8'h00},  // list now full
      '{16'h0008, 1'b1, 1'b0, 8'h00, 8'h00},  // oldest key dropped
      '{16'h0000, 1'b1, 1'b0, 8'h00, 8'h00},  // no key pressed into a full list
      '{16'h0007, 1'b1, 1'b0, 8'h00, 8'h00},
      '{16'h0007, 1'b0, 1'b0, 8'h00, 8'h00},  // clears both copies
      '{16'h0004, 1'b0, 1'b0, 8'h00, 8'h00},  // key not held
      '{16'h0000, 1'b0, 1'b0, 8'h00, 8'h00},
      '{16'hFFFF, 1'b0, 1'b0, 8'h00, 8'h00},
      '{16'h00DF, 1'b1, 1'b0, 8'h00, 8'h00},  // just below the modifier range
      '{16'h00E8, 1'b1, 1'b0, 8'h00, 8'h00},  // just above it
      '{16'h01E3, 1'b1, 1'b0, 8'h00, 8'h00},  // modifier low byte with a high byte
      '{16'h00E0, 1'b0, 1'b0, 8'h00, 8'h00},
      '{16'h00E7, 1'b0, 1'b0, 8'h00, 8'h00},
      '{16'h0105, 1'b0, 1'b0, 8'h00, 8'h00},
      '{16'h8006, 1'b0, 1'b0, 8'h00, 8'h00},
      '{16'h0008, 1'b0, 1'b0, 8'h00, 8'h00},
      '{16'h01E3, 1'b0, 1'b0, 8'h00, 8'h00}
    };
    pool = '{16'h0004, 16'h0005, 16'h0016, 16'h0029, 16'h002C, 16'h0039,
             16'h0204, 16'h1011, 16'h8028, 16'hFF00, 16'h00FF, 16'h0000};

    for (int i = 0; i < Slots; i++) held_keys[i] = NoKey;
    held_mods     = '0;
    quiet_gaps    = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      lit_rep      = '0;
      lit_rep.mods = rows[i].lit_mods;
      lit_rep.keys[0] = rows[i].lit_key0;
      send_key_event(rows[i].code, rows[i].pressed, rows[i].literal, lit_rep, 1'b0);
    end

    for (int n = 0; n < RandEvents; n++) begin
      // Mix stretches with random gaps and stretches at full rate, chosen at random.
      if (n % 100 == 0) quiet_gaps = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        code    = 16'h00E0 | 16'($urandom_range(0, 7));
        pressed = 1'($urandom_range(0, 1));
      end else if (pick < 55) begin
        pressed = 1'b1;
        pick = $urandom_range(0, 99);
        if (pick < 70) code = pool[$urandom_range(0, 11)];
        else if (pick < 95) code = 16'($urandom_range(0, 16'hFFFF));
        else code = NoKey;
      end else if (pick < 85) begin
        pressed = 1'b0;
        used = keys_in_use();
        code = (used > 0) ? held_keys[$urandom_range(0, used - 1)]
                          : pool[$urandom_range(0, 11)];
      end else begin
        pressed = 1'b0;
        code = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 11)]
                                          : 16'($urandom_range(0, 16'hFFFF));
      end
      send_key_event(code, pressed, 1'b0, '0, (n == 0) || (n == 400));
    end
    s_axis_tvalid <= 1'b0;

    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Covered %0d key presses, %0d releases and %0d modifier events,",
             n_press, n_release, n_mod);
    $display("with %0d oldest-key drops on a full list; %0d reports checked.",
             n_drop, n_reports);
    if (err_cnt == 0) begin
      $display("tb_hid_key_report_builder OK");
    end else begin
      $display("tb_hid_key_report_builder NOT OK");
    end
    $finish;
  end

endmodule
